>>> src/msce_pkg.sv
// ----------------------------------------------------------------------------
// msce_pkg
// Shared types, mode codes and CRC constants for the multi-standard CRC
// engine.
// ----------------------------------------------------------------------------
package msce_pkg;

  typedef logic [1:0] crc_mode_t;

  // Mode codes; the unused code runs as CRC-32
  localparam crc_mode_t MODE_CRC32 = 2'd0;
  localparam crc_mode_t MODE_CRC16 = 2'd1;
  localparam crc_mode_t MODE_CRC7  = 2'd2;
  localparam crc_mode_t MODE_SPARE = 2'd3;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [31:0] POLY_CRC32 = 32'hEDB8_8320;
  localparam logic [15:0] POLY_CRC16 = 16'hA001;
  localparam logic [7:0]  POLY_CRC7  = 8'h12;      // 0x09 held left-aligned
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] SEED_ZERO  = 32'h0000_0000;

  // Fold the unused code onto CRC-32
  function automatic crc_mode_t eff_mode(input crc_mode_t mode);
    crc_mode_t m;
    m = (mode == MODE_SPARE) ? MODE_CRC32 : mode;
    return m;
  endfunction

  // Seed of a mode
  function automatic logic [31:0] seed_of(input crc_mode_t mode);
    logic [31:0] s;
    s = (eff_mode(mode) == MODE_CRC32) ? ALL_ONES : SEED_ZERO;
    return s;
  endfunction

endpackage

>>> src/msce_fold.sv
// ----------------------------------------------------------------------------
// msce_fold
// Folds one message byte into the running CRC for the selected mode and
// forms the finished checksum that would go out if the byte is the last.
// ----------------------------------------------------------------------------
module msce_fold import msce_pkg::*; (
  input  crc_mode_t          mode,
  input  logic [CRC_W-1:0]   crc_in,
  input  logic [BYTE_W-1:0]  data_in,
  output logic [CRC_W-1:0]   crc_out,
  output logic [CRC_W-1:0]   result
);

  logic [31:0] r32;
  logic [15:0] r16;
  logic [7:0]  r7;

  // Reflected CRC-32: eight bit steps, LSB first
  always_comb begin
    r32 = crc_in ^ {24'h0, data_in};
    for (int i = 0; i < 8; i++) begin
      r32 = r32[0] ? ((r32 >> 1) ^ POLY_CRC32) : (r32 >> 1);
    end
  end

  // Reflected CRC-16: eight bit steps, LSB first
  always_comb begin
    r16 = crc_in[15:0] ^ {8'h0, data_in};
    for (int i = 0; i < 8; i++) begin
      r16 = r16[0] ? ((r16 >> 1) ^ POLY_CRC16) : (r16 >> 1);
    end
  end

  // CRC-7 held left-aligned in a byte: eight bit steps, MSB first
  always_comb begin
    r7 = crc_in[7:0] ^ data_in;
    for (int i = 0; i < 8; i++) begin
      r7 = r7[7] ? ((r7 << 1) ^ POLY_CRC7) : (r7 << 1);
    end
  end

  // Pick the mode's new register and finished value
  always_comb begin
    unique case (eff_mode(mode))
      MODE_CRC16: begin
        crc_out = {16'h0, r16};
        result  = {16'h0, r16};
      end
      MODE_CRC7: begin
        crc_out = {24'h0, r7};
        result  = {25'h0, r7[7:1]};
      end
      default: begin
        crc_out = r32;
        result  = r32 ^ ALL_ONES;
      end
    endcase
  end

endmodule

>>> src/multi_standard_crc_engine.sv
// ----------------------------------------------------------------------------
// multi_standard_crc_engine
// Byte-wide CRC engine for CRC-32/ISO-HDLC, CRC-16/ARC and CRC-7/MMC.
// ----------------------------------------------------------------------------
// Path: a last beat passes the input register, then the result register,
//   before its checksum shows on the output.
// Throughput: one byte per cycle while the result register can take a checksum; the byte fold is one pass of XOR logic
//   between the input register and the running CRC register.
// Reset: mode returns to CRC-32, the CRC register takes the CRC-32 seed and
//   both stages empty. A mode write reseeds the CRC register.
module multi_standard_crc_engine import msce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       crc_value
);

  crc_mode_t          crc_mode;
  logic [CRC_W-1:0]   crc_reg;
  logic               s1_valid;
  logic [BYTE_W-1:0]  s1_byte;
  logic               s1_last;
  logic               advance;
  logic [CRC_W-1:0]   fold_crc;
  logic [CRC_W-1:0]   fold_result;

  // Move the held beat on unless it finishes a message while the output is full and not taken
  assign advance  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  msce_fold u_fold (
    .mode    (crc_mode),
    .crc_in  (crc_reg),
    .data_in (s1_byte),
    .crc_out (fold_crc),
    .result  (fold_result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // Mode register and running CRC; reseed on mode write or message end
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= MODE_CRC32;
      crc_reg  <= seed_of(MODE_CRC32);
    end else if (cfg_wr_en) begin
      crc_mode <= cfg_wr_data;
      crc_reg  <= seed_of(cfg_wr_data);
    end else if (advance) begin
      crc_reg  <= s1_last ? seed_of(crc_mode) : fold_crc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      crc_value <= fold_result;
    end
  end

  // A held beat that cannot move stays held
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("held input beat lost");

  // A finished message always reaches the result register
  assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> out_valid)
    else $error("finished checksum not presented");

  // The register reseeds after a message end
  assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last && !cfg_wr_en) |=> (crc_reg == seed_of(crc_mode)))
    else $error("CRC register not reseeded");

  // Narrow modes keep the upper register bits clear
  assert property (@(posedge clk) disable iff (rst)
    (crc_mode == MODE_CRC16) |-> (crc_reg[31:16] == 16'h0))
    else $error("CRC-16 register overflow");

  assert property (@(posedge clk) disable iff (rst)
    (crc_mode == MODE_CRC7) |-> (crc_reg[31:8] == 24'h0))
    else $error("CRC-7 register overflow");

endmodule

>>> test/tb_multi_standard_crc_engine.sv
// ----------------------------------------------------------------------------
// tb_multi_standard_crc_engine
// Self-checking bench for the byte-wide CRC-32 / CRC-16 / CRC-7 engine.
// A short table of hand-picked bytes and mode writes, some with known
// checksums, runs first. Random messages follow in every mode under several
// sender and receiver idle patterns. Checksums with no known value are
// compared with a bit-serial model kept in the bench.
// ----------------------------------------------------------------------------
module tb_multi_standard_crc_engine;
  import msce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 4;
  localparam int QUIET_LIMIT  = 4000;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_BYTES  = 75;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte   = 8'h00;
  logic        last_byte   = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [31:0] crc_value;

  // Bench-side copy of the engine state
  crc_mode_t   active_mode;
  logic [31:0] crc_run;
  logic [31:0] crc_expect_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_bytes        = 0;
  int n_msgs         = 0;
  int n_checked      = 0;
  int n_cfg          = 0;
  int n_mismatch     = 0;
  int quiet_cycles   = 0;

  // Directed stimulus: a mode write or one byte, with an optional known sum
  typedef struct packed {
    logic        is_cfg;
    crc_mode_t   mode;
    logic [7:0]  data;
    logic        last;
    logic        known;
    logic [31:0] want;
  } stim_row_t;

  localparam int DIR_ROWS = 23;

  stim_row_t dir_tab [DIR_ROWS] = '{
    // CRC-32 straight out of reset: single bytes, then the standard check string
    '{1'b0, MODE_CRC32, 8'h00, 1'b1, 1'b1, 32'hD202_EF8D},
    '{1'b0, MODE_CRC32, 8'hFF, 1'b1, 1'b1, 32'hFF00_0000},
    '{1'b0, MODE_CRC32, 8'h31, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'h32, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'h33, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'h34, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'h35, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'h36, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'h37, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'h38, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'h39, 1'b1, 1'b1, 32'hCBF4_3926},
    // CRC-16, then leave a message open and switch mode under it
    '{1'b1, MODE_CRC16, 8'h00, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'hFF, 1'b1, 1'b1, 32'h0000_4040},
    '{1'b0, MODE_CRC32, 8'h00, 1'b1, 1'b1, 32'h0000_0000},
    '{1'b0, MODE_CRC32, 8'hA5, 1'b0, 1'b0, 32'h0},
    '{1'b1, MODE_CRC7,  8'h00, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'hFF, 1'b1, 1'b1, 32'h0000_0079},
    '{1'b0, MODE_CRC32, 8'h00, 1'b1, 1'b1, 32'h0000_0000},
    // Unused mode code runs as CRC-32
    '{1'b1, MODE_SPARE, 8'h00, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'h00, 1'b1, 1'b1, 32'hD202_EF8D},
    '{1'b0, MODE_CRC32, 8'h5A, 1'b0, 1'b0, 32'h0},
    '{1'b0, MODE_CRC32, 8'hC3, 1'b1, 1'b0, 32'h0},
    '{1'b1, MODE_CRC32, 8'h00, 1'b0, 1'b0, 32'h0}
  };

  crc_mode_t phase_mode [NUM_PHASES] = '{MODE_CRC32, MODE_CRC16, MODE_CRC7, MODE_SPARE,
                                         MODE_CRC7, MODE_CRC16, MODE_CRC32, MODE_CRC7};
  int phase_send_idle  [NUM_PHASES] = '{0, 70, 0, 20, 0, 70, 0, 20};
  int phase_recv_stall [NUM_PHASES] = '{0, 0, 70, 20, 0, 0, 70, 20};

  multi_standard_crc_engine u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .crc_value   (crc_value)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Starting value of the running CRC for a mode
  function automatic logic [31:0] mode_seed(input crc_mode_t m);
    return (m == MODE_CRC16 || m == MODE_CRC7) ? 32'h0 : ALL_ONES;
  endfunction

  // Fold one byte into the running CRC, one bit at a time
  function automatic logic [31:0] fold_byte(input crc_mode_t m, input logic [31:0] r,
                                            input logic [7:0] b);
    logic [31:0] x;
    int i;
    case (m)
      MODE_CRC16: begin
        x = {16'h0, r[15:0] ^ {8'h00, b}};
        for (i = 0; i < 8; i++)
          x = x[0] ? ((x >> 1) ^ {16'h0, POLY_CRC16}) : (x >> 1);
      end
      MODE_CRC7: begin
        x = {24'h0, r[7:0] ^ b};
        for (i = 0; i < 8; i++)
          x = x[7] ? ({24'h0, x[6:0], 1'b0} ^ {24'h0, POLY_CRC7}) : {24'h0, x[6:0], 1'b0};
      end
      default: begin
        x = r ^ {24'h0, b};
        for (i = 0; i < 8; i++)
          x = x[0] ? ((x >> 1) ^ POLY_CRC32) : (x >> 1);
      end
    endcase
    return x;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("%0t ns: %s: expected %08h, got %08h", $realtime, what, want, got);
  endtask

  // Offer one beat, hold it until taken, then advance the bench's CRC
  task automatic push_byte(input logic [7:0] b, input logic l, input logic known,
                           input logic [31:0] want);
    logic [31:0] sum;
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
    n_bytes++;
    crc_run = fold_byte(active_mode, crc_run, b);
    if (l) begin
      case (active_mode)
        MODE_CRC16: sum = crc_run;
        MODE_CRC7:  sum = crc_run >> 1;
        default:    sum = crc_run ^ ALL_ONES;
      endcase
      crc_expect_q.push_back(known ? want : sum);
      crc_run = mode_seed(active_mode);
      n_msgs++;
    end
  endtask

  // Drop valid, drain the engine, then write the mode register
  task automatic set_crc_mode(input crc_mode_t m);
    in_valid <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_mode = m;
    crc_run     = mode_seed(m);
    n_cfg++;
  endtask

  // Result side: random back-pressure and the checksum compare
  always @(posedge clk) begin : rx_check
    logic [31:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (crc_expect_q.size() == 0) begin
          flag_mismatch("checksum with no message pending", 32'h0, crc_value);
        end else begin
          want = crc_expect_q.pop_front();
          if (crc_value !== want)
            flag_mismatch("crc_value", want, crc_value);
          n_checked++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t ns: no beat moved in %0d cycles", $realtime, QUIET_LIMIT);
      $display("multi_standard_crc_engine test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          row;
    int          ph;
    int          sent;
    int          len;
    int          k;
    logic [7:0]  b;
    logic        l;

    active_mode = MODE_CRC32;
    crc_run     = mode_seed(MODE_CRC32);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table, no idling on either side
    for (row = 0; row < DIR_ROWS; row++) begin
      if (dir_tab[row].is_cfg)
        set_crc_mode(dir_tab[row].mode);
      else
        push_byte(dir_tab[row].data, dir_tab[row].last, dir_tab[row].known,
                  dir_tab[row].want);
    end

    // Random messages; a phase may end inside a message, which the next
    // mode write abandons
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = phase_send_idle[ph];
      recv_stall_pct = phase_recv_stall[ph];
      set_crc_mode(phase_mode[ph]);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len && sent < PHASE_BYTES; k++) begin
          case ($urandom_range(0, 9))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
          endcase
          l = (k == len - 1);
          push_byte(b, l, 1'b0, 32'h0);
          sent++;
          if (l && (n_msgs % 20 == 7)) begin
            // Hold off until every pending checksum is out
            in_valid <= 1'b0;
            do @(posedge clk); while (crc_expect_q.size() != 0);
          end else if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
          end
        end
      end
    end

    // Drain and finish
    in_valid <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d messages over %0d mode writes (all four codes).",
             n_bytes, n_msgs, n_cfg);
    $display("Checked %0d checksums under mixed stalls; %0d mismatches.",
             n_checked, n_mismatch);
    if (n_mismatch == 0)
      $display("multi_standard_crc_engine test passed");
    else
      $display("multi_standard_crc_engine test failed");
    $finish;
  end

endmodule

>>> filelist.f
src/msce_pkg.sv
src/msce_fold.sv
src/multi_standard_crc_engine.sv
test/tb_multi_standard_crc_engine.sv
